[sv/lcfs_pkg.sv]
`timescale 1ns / 1ps

package lcfs_pkg;

  localparam int BYTE_W     = 8;
  localparam int POS_W      = 9;
  localparam int COUNT_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [POS_W-1:0]  POS_HUNT   = 9'd0;
  localparam logic [POS_W-1:0]  POS_LENGTH = 9'd1;
  localparam logic [POS_W-1:0]  POS_CHECK  = 9'd2;
  localparam logic [POS_W-1:0]  HEADER_LEN = 9'd3;
  localparam logic [BYTE_W-1:0] COMPLEMENT_CHECK = 8'hFF;

  localparam logic [BYTE_W-1:0] START_BYTE_RESET    = 8'hAA;
  localparam logic [POS_W-1:0]  MIN_FRAME_LEN_RESET = 9'd12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BYTE    = 2'd0,
    CFG_MIN_FRAME_LEN = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  frame_byte;
    logic [BYTE_W-1:0]  byte_index;
    logic               frame_last;
    logic [COUNT_W-1:0] garbled_count;
  } result_t;

endpackage

[sv/length_checked_frame_sync.sv]
`timescale 1ns / 1ps
// Byte-stream frame sync with length/complement header check.
//
// Input channel (in_valid/in_stall, rx_byte): one received byte per request.
// Output channel (out_valid/out_stall): frame_byte, byte_index, frame_last and
// the running garbled_count after the byte that produced the request.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): cfg_ready is
// always high; index 0 is start_byte, 1 is min_frame_len, others are ignored.
//
// Each accepted byte updates the hunt state in the same cycle and loads its
// results into a four-entry output queue, so the first result shows in the
// cycle after acceptance. A verified header releases three results and input
// stalls while two or more results are waiting.
// With no output stall the block takes one byte per cycle in the frame body.
//
// Reset (rst, synchronous) empties the queue, returns to hunting, clears the
// garble counter and restores start_byte = 0xAA, min_frame_len = 12.
// When the receiver stalls, the head result holds and the queue fills; input
// stalls once it cannot hold another header's three results.
module length_checked_frame_sync #(
  parameter int MAX_FRAME_LEN = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lcfs_pkg::BYTE_W-1:0]       rx_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lcfs_pkg::BYTE_W-1:0]       frame_byte,
  output logic [lcfs_pkg::BYTE_W-1:0]       byte_index,
  output logic                              frame_last,
  output logic [lcfs_pkg::COUNT_W-1:0]      garbled_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lcfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcfs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lcfs_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam logic [POS_W:0] MAX_LEN = (POS_W + 1)'(MAX_FRAME_LEN);

  logic [BYTE_W-1:0]  start_byte;
  logic [POS_W-1:0]   min_frame_len;
  logic [POS_W-1:0]   position, position_next;
  logic [POS_W-1:0]   frame_length, frame_length_next;
  logic [BYTE_W-1:0]  length_byte, length_byte_next;
  logic [COUNT_W-1:0] garble_counter, garble_counter_next;

  result_t            queue [QDEPTH];
  result_t            queue_next [QDEPTH];
  logic [QCNT_W-1:0]  count, count_next;

  result_t            push_entry [3];
  logic [1:0]         push_n;
  logic               accept, pop;
  logic [QCNT_W-1:0]  base;
  logic [POS_W-1:0]   hdr_len;
  logic [POS_W-1:0]   pos_inc;
  logic               hdr_ok;

  assign cfg_ready = 1'b1;
  assign out_valid = (count != '0);
  assign in_stall  = (count > QCNT_W'(QDEPTH - 3));
  assign accept    = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  assign frame_byte    = queue[0].frame_byte;
  assign byte_index    = queue[0].byte_index;
  assign frame_last    = queue[0].frame_last;
  assign garbled_count = queue[0].garbled_count;

  assign hdr_len = {1'b0, length_byte} + HEADER_LEN;
  assign pos_inc = position + 9'd1;
  assign hdr_ok  = ((length_byte ^ rx_byte) == COMPLEMENT_CHECK) &&
                   (hdr_len >= min_frame_len) &&
                   ({1'b0, hdr_len} <= MAX_LEN);

  always_comb begin
    position_next       = position;
    frame_length_next   = frame_length;
    length_byte_next    = length_byte;
    garble_counter_next = garble_counter;
    push_n              = 2'd0;
    for (int k = 0; k < 3; k++) begin
      push_entry[k] = '0;
    end
    if (accept) begin
      case (position)
        POS_HUNT: begin
          if (rx_byte == start_byte) begin
            position_next = POS_LENGTH;
          end else begin
            garble_counter_next = garble_counter + 32'd1;
          end
        end
        POS_LENGTH: begin
          length_byte_next = rx_byte;
          position_next    = POS_CHECK;
        end
        POS_CHECK: begin
          frame_length_next = hdr_len;
          if (!hdr_ok) begin
            garble_counter_next = garble_counter + 32'(HEADER_LEN);
            position_next       = POS_HUNT;
          end else begin
            push_n        = 2'd3;
            position_next = (hdr_len <= HEADER_LEN) ? POS_HUNT : HEADER_LEN;
            push_entry[0] = '{start_byte, 8'd0, 1'b0, garble_counter};
            push_entry[1] = '{length_byte, 8'd1, 1'b0, garble_counter};
            push_entry[2] = '{rx_byte, 8'd2, (hdr_len <= HEADER_LEN), garble_counter};
          end
        end
        default: begin
          // frame body; the 9-bit wrap also ends the frame
          push_n        = 2'd1;
          push_entry[0] = '{rx_byte, position[BYTE_W-1:0], 1'b0, garble_counter};
          if (pos_inc >= frame_length || pos_inc == '0) begin
            push_entry[0].frame_last = 1'b1;
            position_next            = POS_HUNT;
          end else begin
            position_next = pos_inc;
          end
        end
      endcase
    end
  end

  always_comb begin
    base = count - QCNT_W'(pop);
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) begin
        queue_next[i] = queue[i + 1];
      end else begin
        queue_next[i] = queue[i];
      end
      for (int k = 0; k < 3; k++) begin
        if (k < int'(push_n) && (base + QCNT_W'(k)) == QCNT_W'(i)) begin
          queue_next[i] = push_entry[k];
        end
      end
    end
    count_next = base + QCNT_W'(push_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte     <= START_BYTE_RESET;
      min_frame_len  <= MIN_FRAME_LEN_RESET;
      position       <= POS_HUNT;
      frame_length   <= '0;
      length_byte    <= '0;
      garble_counter <= '0;
      count          <= '0;
    end else begin
      position       <= position_next;
      frame_length   <= frame_length_next;
      length_byte    <= length_byte_next;
      garble_counter <= garble_counter_next;
      count          <= count_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START_BYTE:    start_byte    <= cfg_data[BYTE_W-1:0];
          CFG_MIN_FRAME_LEN: min_frame_len <= cfg_data[POS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      queue[i] <= queue_next[i];
    end
  end

endmodule

[sv/lcfs_checker.sv]
`timescale 1ns / 1ps

module lcfs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [lcfs_pkg::BYTE_W-1:0]     frame_byte,
  input logic [lcfs_pkg::BYTE_W-1:0]     byte_index,
  input logic                            frame_last,
  input logic [lcfs_pkg::COUNT_W-1:0]    garbled_count
);
  import lcfs_pkg::*;

  // reset empties the output queue
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // an empty queue always has room for a header
  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output queue");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(frame_byte) && $stable(byte_index) &&
       $stable(frame_last) && $stable(garbled_count)))
    else $error("stalled output request changed");

  // no byte is discarded inside a frame
  a_count_in_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !frame_last) |=>
      (!out_valid || garbled_count == $past(garbled_count)))
    else $error("garbled count moved inside a frame");

endmodule

bind length_checked_frame_sync lcfs_checker u_lcfs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .frame_byte    (frame_byte),
  .byte_index    (byte_index),
  .frame_last    (frame_last),
  .garbled_count (garbled_count)
);
